>>> rtl/tcc_pkg.sv
// Shared constants and types of the text console controller.
// Holds field widths, control character codes and the cursor decode struct.
// No dependencies.
package tcc_pkg;

    // Default screen geometry
    localparam int ROWS_DEF = 25;
    localparam int COLS_DEF = 80;

    // Fixed field widths of the item and result beats
    localparam int ROW_FW  = 5;
    localparam int COL_FW  = 7;
    localparam int LIN_FW  = 11;
    localparam int CELL_W  = 16;
    localparam int ATTR_W  = 8;
    localparam int CHAR_W  = 8;

    // Configuration port
    localparam int APB_AW = 2;
    localparam int APB_DW = 32;
    localparam logic [APB_AW-1:0] ADDR_TEXT_ATTR = 2'd0;
    localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h0F;

    // Control and printable character codes
    localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
    localparam logic [CHAR_W-1:0] CH_FF    = 8'd12;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
    localparam logic [CHAR_W-1:0] PRINT_HI = 8'd127;
    localparam int TAB_STEP = 8;

    // Actions
    localparam logic ACT_PUT  = 1'b0;
    localparam logic ACT_READ = 1'b1;

    // What a put byte does to the cell store
    typedef struct packed {
        logic write_cell;
        logic scroll;
        logic clear;
    } t_put_ctl;

endpackage

>>> rtl/tcc_cursor.sv
// Next-cursor decode of the text console controller for one put byte.
// Tracks row, column and linear position; flags cell write, scroll, clear.
// Depends on tcc_pkg.
module tcc_cursor #(
    parameter int ROWS = tcc_pkg::ROWS_DEF,
    parameter int COLS = tcc_pkg::COLS_DEF
) (
    input  logic [tcc_pkg::CHAR_W-1:0]  i_byte,
    input  logic [$clog2(ROWS)-1:0]     i_row,
    input  logic [$clog2(COLS)-1:0]     i_col,
    input  logic [$clog2(ROWS*COLS)-1:0] i_lin,
    output logic [$clog2(ROWS)-1:0]     o_row,
    output logic [$clog2(COLS)-1:0]     o_col,
    output logic [$clog2(ROWS*COLS)-1:0] o_lin,
    output tcc_pkg::t_put_ctl           o_ctl
);
    localparam int ROW_W = $clog2(ROWS);
    localparam int COL_W = $clog2(COLS);
    localparam int LIN_W = $clog2(ROWS*COLS);

    logic                last_col;
    logic                last_row;
    logic [LIN_W-1:0]    row_base;
    logic [COL_W:0]      tab_sum;
    logic [COL_W-1:0]    tab_col;
    logic                printable;

    assign last_col  = (i_col == COL_W'(COLS - 1));
    assign last_row  = (i_row == ROW_W'(ROWS - 1));
    assign row_base  = i_lin - LIN_W'(i_col);
    assign tab_sum   = (COL_W+1)'(i_col) + (COL_W+1)'(tcc_pkg::TAB_STEP);
    assign tab_col   = (tab_sum > (COL_W+1)'(COLS - 1)) ? COL_W'(COLS - 1)
                                                        : tab_sum[COL_W-1:0];
    assign printable = (i_byte >= tcc_pkg::CH_SPACE) && (i_byte <= tcc_pkg::PRINT_HI);

    always_comb begin
        o_row = i_row;
        o_col = i_col;
        o_lin = i_lin;
        o_ctl = '0;
        if (printable) begin
            o_ctl.write_cell = 1'b1;
            if (last_col && last_row) begin
                o_ctl.scroll = 1'b1;
                o_row = ROW_W'(ROWS - 1);
                o_col = '0;
                o_lin = LIN_W'((ROWS - 1) * COLS);
            end else if (last_col) begin
                o_row = i_row + 1'b1;
                o_col = '0;
                o_lin = i_lin + 1'b1;
            end else begin
                o_col = i_col + 1'b1;
                o_lin = i_lin + 1'b1;
            end
        end else begin
            unique case (i_byte)
                tcc_pkg::CH_BS: begin
                    if (i_col != '0) begin
                        o_col = i_col - 1'b1;
                        o_lin = i_lin - 1'b1;
                    end
                end
                tcc_pkg::CH_TAB: begin
                    o_col = tab_col;
                    o_lin = row_base + LIN_W'(tab_col);
                end
                tcc_pkg::CH_LF: begin
                    if (last_row) begin
                        o_ctl.scroll = 1'b1;
                        o_row = ROW_W'(ROWS - 1);
                        o_col = '0;
                        o_lin = LIN_W'((ROWS - 1) * COLS);
                    end else begin
                        o_row = i_row + 1'b1;
                        o_col = '0;
                        o_lin = row_base + LIN_W'(COLS);
                    end
                end
                tcc_pkg::CH_FF: begin
                    o_ctl.clear = 1'b1;
                    o_row = '0;
                    o_col = '0;
                    o_lin = '0;
                end
                tcc_pkg::CH_CR: begin
                    o_col = '0;
                    o_lin = row_base;
                end
                default: begin
                    // ignore every other byte
                end
            endcase
        end
    end

endmodule

>>> rtl/text_console_controller.sv
// Top level of the text console controller: cell memory, sequencer, ports.
// Depends on tcc_pkg and tcc_cursor.
//
// Usage
//   Input channel (i_valid / o_ready) carries one beat per action: a put of
//   i_char_byte, or a read of the cell at i_read_row / i_read_col. Output
//   channel (o_valid / i_ready) returns one beat per input beat, in order,
//   with the cursor after the action, the read cell (0 for a put or an out of
//   range read) and the echoed last_byte flag (0 for a read).
//   Reads, printable bytes and cursor moves: the accepting cycle issues the
//   memory access, then the FIN state collects the synchronous read data and
//   loads the output register; no new beat is accepted before that.
//   Scroll (printable byte in the last cell, line feed in the last row) walks
//   the single-write-port memory one cell per cycle: copy rows up, then
//   blank the last row's COLS cells. Form feed blanks all ROWS*COLS cells.
//   Reset: a clearing pass writes the blank cell to all ROWS*COLS entries,
//   during which no beat is accepted; the APB port stays live.
//   text_attribute resets to 0x0F.
//   Stall: a finished result waits in the output register; the next input
//   beat is still accepted and worked on, and its result waits until the
//   output register drains.
module text_console_controller #(
    parameter int ROWS = tcc_pkg::ROWS_DEF,
    parameter int COLS = tcc_pkg::COLS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_action,
    input  logic [tcc_pkg::CHAR_W-1:0]    i_char_byte,
    input  logic [tcc_pkg::ROW_FW-1:0]    i_read_row,
    input  logic [tcc_pkg::COL_FW-1:0]    i_read_col,
    input  logic                          i_last_byte,
    // output channel
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [tcc_pkg::ROW_FW-1:0]    o_cursor_row,
    output logic [tcc_pkg::COL_FW-1:0]    o_cursor_col,
    output logic [tcc_pkg::LIN_FW-1:0]    o_cursor_linear,
    output logic [tcc_pkg::CELL_W-1:0]    o_cell_data,
    output logic                          o_call_done,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tcc_pkg::APB_AW-1:0]    paddr,
    input  logic [tcc_pkg::APB_DW-1:0]    pwdata,
    output logic [tcc_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);
    localparam int NCELLS = ROWS * COLS;
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLS);
    localparam int LIN_W  = $clog2(NCELLS);
    localparam int RDP_W  = tcc_pkg::ROW_FW + COL_W;
    localparam int NCOPY  = (ROWS - 1) * COLS;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_FIN   = 2'd1;
    localparam logic [1:0] S_COPY  = 2'd2;
    localparam logic [1:0] S_SWEEP = 2'd3;

    localparam logic [tcc_pkg::CELL_W-1:0] RESET_BLANK = {tcc_pkg::RESET_ATTR,
                                                          tcc_pkg::CH_SPACE};

    // Cell memory: one write port, one registered read port
    logic [tcc_pkg::CELL_W-1:0] mem [NCELLS];
    logic [tcc_pkg::CELL_W-1:0] r_rdata;

    logic [1:0]                   r_state;
    logic [LIN_W-1:0]             r_cnt;
    logic [tcc_pkg::CELL_W-1:0]   r_fill;
    logic                         r_reply;
    logic [ROW_W-1:0]             r_row;
    logic [COL_W-1:0]             r_col;
    logic [LIN_W-1:0]             r_lin;
    logic [tcc_pkg::ATTR_W-1:0]   r_attr;
    logic                         r_is_read;
    logic                         r_rd_ok;
    logic                         r_done;

    logic                         r_ovalid;
    logic [tcc_pkg::ROW_FW-1:0]   r_orow;
    logic [tcc_pkg::COL_FW-1:0]   r_ocol;
    logic [tcc_pkg::LIN_FW-1:0]   r_olin;
    logic [tcc_pkg::CELL_W-1:0]   r_ocell;
    logic                         r_odone;

    logic                         accept;
    logic                         out_free;
    logic [ROW_W-1:0]             n_row;
    logic [COL_W-1:0]             n_col;
    logic [LIN_W-1:0]             n_lin;
    tcc_pkg::t_put_ctl            put_ctl;
    logic [RDP_W-1:0]             rd_pos;
    logic                         rd_in_range;
    logic                         wr_en;
    logic [LIN_W-1:0]             wr_addr;
    logic [tcc_pkg::CELL_W-1:0]   wr_data;
    logic                         rd_en;
    logic [LIN_W-1:0]             rd_addr;
    logic [LIN_W:0]               copy_src;

    tcc_cursor #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_cursor (
        .i_byte (i_char_byte),
        .i_row  (r_row),
        .i_col  (r_col),
        .i_lin  (r_lin),
        .o_row  (n_row),
        .o_col  (n_col),
        .o_lin  (n_lin),
        .o_ctl  (put_ctl)
    );

    assign o_ready  = (r_state == S_IDLE);
    assign accept   = i_valid && o_ready;
    assign out_free = !r_ovalid || i_ready;

    // Read position of a read beat; out of range reads return zero
    assign rd_pos      = RDP_W'(i_read_row) * RDP_W'(COLS) + RDP_W'(i_read_col);
    assign rd_in_range = (32'(i_read_row) < 32'(ROWS)) && (32'(i_read_col) < 32'(COLS));
    assign copy_src    = (LIN_W+1)'(r_cnt) + (LIN_W+1)'(COLS);

    // Memory port steering
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_lin;
        wr_data = {r_attr, i_char_byte};
        rd_en   = 1'b0;
        rd_addr = LIN_W'(rd_pos);
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_action == tcc_pkg::ACT_PUT && put_ctl.write_cell) begin
                    wr_en = 1'b1;
                end
                rd_en = accept && i_action == tcc_pkg::ACT_READ && rd_in_range;
            end
            S_COPY: begin
                // read row below, write back the cell read for the previous count
                rd_en   = (32'(r_cnt) < NCOPY);
                rd_addr = copy_src[LIN_W-1:0];
                wr_en   = (r_cnt != '0);
                wr_addr = r_cnt - 1'b1;
                wr_data = r_rdata;
            end
            S_SWEEP: begin
                wr_en   = 1'b1;
                wr_addr = r_cnt;
                wr_data = r_fill;
            end
            S_FIN: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    // Configuration register
    assign pready = 1'b1;
    assign prdata = (paddr == tcc_pkg::ADDR_TEXT_ATTR) ? tcc_pkg::APB_DW'(r_attr) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= tcc_pkg::RESET_ATTR;
        end else if (psel && penable && pwrite && pready) begin
            r_attr <= pwdata[tcc_pkg::ATTR_W-1:0];
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SWEEP;
            r_cnt   <= '0;
            r_fill  <= RESET_BLANK;
            r_reply <= 1'b0;
            r_row   <= '0;
            r_col   <= '0;
            r_lin   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_is_read <= (i_action == tcc_pkg::ACT_READ);
                        r_rd_ok   <= rd_in_range;
                        r_done    <= (i_action == tcc_pkg::ACT_PUT) && i_last_byte;
                        r_state   <= S_FIN;
                        if (i_action == tcc_pkg::ACT_PUT) begin
                            r_row <= n_row;
                            r_col <= n_col;
                            r_lin <= n_lin;
                            r_cnt <= '0;
                            if (put_ctl.scroll) begin
                                r_state <= S_COPY;
                            end else if (put_ctl.clear) begin
                                r_state <= S_SWEEP;
                                r_fill  <= {r_attr, tcc_pkg::CH_SPACE};
                                r_reply <= 1'b1;
                            end
                        end
                    end
                end
                S_COPY: begin
                    if (32'(r_cnt) == NCOPY) begin
                        // counter already points at the last row: blank it
                        r_state <= S_SWEEP;
                        r_fill  <= {r_attr, tcc_pkg::CH_SPACE};
                        r_reply <= 1'b1;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_SWEEP: begin
                    if (32'(r_cnt) == NCELLS - 1) begin
                        r_state <= r_reply ? S_FIN : S_IDLE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_FIN: begin
                    // hold until the output register can take the result
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == S_FIN && out_free) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN && out_free) begin
            r_orow  <= tcc_pkg::ROW_FW'(r_row);
            r_ocol  <= tcc_pkg::COL_FW'(r_col);
            r_olin  <= tcc_pkg::LIN_FW'(r_lin);
            r_ocell <= (r_is_read && r_rd_ok) ? r_rdata : '0;
            r_odone <= r_done;
        end
    end

    assign o_valid         = r_ovalid;
    assign o_cursor_row    = r_orow;
    assign o_cursor_col    = r_ocol;
    assign o_cursor_linear = r_olin;
    assign o_cell_data     = r_ocell;
    assign o_call_done     = r_odone;

    // Linear cursor tracks row and column
    a_lin_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_lin) == 32'(r_row) * 32'(COLS) + 32'(r_col))
        else $error("linear cursor out of step with row/column");

    a_cursor_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_row) < 32'(ROWS)) && (32'(r_col) < 32'(COLS)))
        else $error("cursor outside the screen");

    a_cnt_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cnt) < NCELLS)
        else $error("sweep counter outside the memory");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state != S_IDLE)
        else $error("accepted beat produced no work");

    a_no_write_on_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_action == tcc_pkg::ACT_READ) |-> !wr_en)
        else $error("read beat wrote the cell memory");

endmodule
